FILE: rtl/tsbc_pkg.sv
// shared types, constants and round functions for the toy spn byte cipher
// no dependencies; used by tsbc_cell and toy_spn_byte_cipher
`default_nettype none

package tsbc_pkg;

    localparam int ROUNDS_DEFAULT = 3;
    localparam int BYTE_W         = 8;
    localparam int NIB_W          = 4;
    localparam int IDX_W          = 3;
    localparam int KEYS_W         = 32;
    localparam int SBOX_W         = 64;
    localparam int PERM_W         = 24;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_KEYS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SBOX         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_SBOX     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERM_MAP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_PERM_MAP = 3'd4;

    // request types
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    // reset values: zero keys, identity tables
    localparam logic [KEYS_W-1:0] KEYS_RESET = 32'h0000_0000;
    localparam logic [SBOX_W-1:0] SBOX_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [PERM_W-1:0] PERM_RESET = 24'hFA_C688;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [SBOX_W-1:0] sbox;
        logic [SBOX_W-1:0] inv_sbox;
        logic [PERM_W-1:0] perm;
        logic [PERM_W-1:0] inv_perm;
    } tables_t;

    // substitute both nibbles through a packed 16-entry table
    function automatic byte_t nib_sub(input logic [SBOX_W-1:0] tbl, input byte_t v);
        logic [NIB_W-1:0] hi;
        logic [NIB_W-1:0] lo;
        hi = v[BYTE_W-1:NIB_W];
        lo = v[NIB_W-1:0];
        return {tbl[NIB_W*hi +: NIB_W], tbl[NIB_W*lo +: NIB_W]};
    endfunction

    // output bit i copies input bit map[i]
    function automatic byte_t bit_perm(input logic [PERM_W-1:0] map, input byte_t v);
        byte_t            r;
        logic [IDX_W-1:0] src;
        r = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            src  = map[IDX_W*i +: IDX_W];
            r[i] = v[src];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tsbc_cell.sv
// one round cell of the cipher chain: round logic plus a valid/data register
// depends on tsbc_pkg (round functions, tables_t)
`default_nettype none

module tsbc_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire                  in_dec,
    input  wire tsbc_pkg::byte_t in_data,
    output logic                 in_ready,
    input  wire tsbc_pkg::byte_t enc_key,
    input  wire tsbc_pkg::byte_t dec_key,
    input  wire tsbc_pkg::tables_t tables,
    input  wire                  take,
    output logic                 out_valid,
    output logic                 out_dec,
    output tsbc_pkg::byte_t      out_data
);

    logic            valid_reg;
    logic            valid_next;
    logic            dec_reg;
    tsbc_pkg::byte_t data_reg;
    tsbc_pkg::byte_t enc_res;
    tsbc_pkg::byte_t dec_res;
    tsbc_pkg::byte_t round_res;

    // encrypt: key, s-box, permutation; decrypt: inverse permutation, inverse s-box, key
    always_comb
    begin
        enc_res   = tsbc_pkg::bit_perm(tables.perm,
                        tsbc_pkg::nib_sub(tables.sbox, in_data ^ enc_key));
        dec_res   = tsbc_pkg::nib_sub(tables.inv_sbox,
                        tsbc_pkg::bit_perm(tables.inv_perm, in_data)) ^ dec_key;
        round_res = (in_dec == tsbc_pkg::REQ_DECRYPT) ? dec_res : enc_res;
    end

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dec_reg  <= in_dec;
            data_reg <= round_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/toy_spn_byte_cipher.sv
// toy spn byte cipher: a request passes through one register per round cell, then the output register;
// throughput one byte per cycle while the result side keeps taking results, set by one round per cell
// in a chain where each cell advances whenever its successor has room
// reset clears all valid bits, keys to zero and all tables to identity
// depends on tsbc_pkg and tsbc_cell
`default_nettype none

module toy_spn_byte_cipher #(
    parameter int ROUNDS = tsbc_pkg::ROUNDS_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write channel
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [tsbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [tsbc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // request channel
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  req_type,
    input  wire [tsbc_pkg::BYTE_W-1:0]           data_in,
    // result channel
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [tsbc_pkg::BYTE_W-1:0]          data_out
);

    // configuration registers
    logic [tsbc_pkg::KEYS_W-1:0] keys_reg;
    tsbc_pkg::tables_t           tables_reg;

    // chain wiring: cell j holds a request after round j of its pass
    logic            cell_valid [ROUNDS];
    logic            cell_dec   [ROUNDS];
    tsbc_pkg::byte_t cell_data  [ROUNDS];
    logic            cell_ready [ROUNDS];
    logic            cell_take  [ROUNDS];

    // output register
    logic            out_valid_reg;
    logic            out_valid_next;
    tsbc_pkg::byte_t out_data_reg;
    logic            out_take;

    tsbc_pkg::byte_t key3;
    tsbc_pkg::byte_t chain_in;
    tsbc_pkg::byte_t chain_out;

    // config writes are always taken; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg            <= tsbc_pkg::KEYS_RESET;
            tables_reg.sbox     <= tsbc_pkg::SBOX_RESET;
            tables_reg.inv_sbox <= tsbc_pkg::SBOX_RESET;
            tables_reg.perm     <= tsbc_pkg::PERM_RESET;
            tables_reg.inv_perm <= tsbc_pkg::PERM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tsbc_pkg::CFG_ROUND_KEYS:   keys_reg <= cfg_data[tsbc_pkg::KEYS_W-1:0];
                tsbc_pkg::CFG_SBOX:         tables_reg.sbox <= cfg_data;
                tsbc_pkg::CFG_INV_SBOX:     tables_reg.inv_sbox <= cfg_data;
                tsbc_pkg::CFG_PERM_MAP:
                    tables_reg.perm <= cfg_data[tsbc_pkg::PERM_W-1:0];
                tsbc_pkg::CFG_INV_PERM_MAP:
                    tables_reg.inv_perm <= cfg_data[tsbc_pkg::PERM_W-1:0];
                default: ;
            endcase
        end
    end

    // final key: whitening on entry for decrypt, on exit for encrypt
    assign key3     = keys_reg[3*tsbc_pkg::BYTE_W +: tsbc_pkg::BYTE_W];
    assign chain_in = (req_type == tsbc_pkg::REQ_DECRYPT) ? (data_in ^ key3) : data_in;

    // backpressure runs from the output register down the chain
    assign out_take = !out_valid_reg || out_ready;
    assign in_ready = cell_ready[0];

    generate
        for (genvar j = 0; j < ROUNDS; j++)
        begin : g_cell
            // encrypt pass uses round j, decrypt pass walks the rounds backward
            localparam int ENC_RND = j;
            localparam int DEC_RND = ROUNDS - 1 - j;

            if (j == ROUNDS - 1)
            begin : g_last
                assign cell_take[j] = out_take;
            end
            else
            begin : g_mid
                assign cell_take[j] = cell_ready[j+1];
            end

            if (j == 0)
            begin : g_first
                tsbc_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (in_valid),
                    .in_dec    (req_type),
                    .in_data   (chain_in),
                    .in_ready  (cell_ready[j]),
                    .enc_key   (keys_reg[ENC_RND*tsbc_pkg::BYTE_W +: tsbc_pkg::BYTE_W]),
                    .dec_key   (keys_reg[DEC_RND*tsbc_pkg::BYTE_W +: tsbc_pkg::BYTE_W]),
                    .tables    (tables_reg),
                    .take      (cell_take[j]),
                    .out_valid (cell_valid[j]),
                    .out_dec   (cell_dec[j]),
                    .out_data  (cell_data[j])
                );
            end
            else
            begin : g_next
                tsbc_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .in_valid  (cell_valid[j-1]),
                    .in_dec    (cell_dec[j-1]),
                    .in_data   (cell_data[j-1]),
                    .in_ready  (cell_ready[j]),
                    .enc_key   (keys_reg[ENC_RND*tsbc_pkg::BYTE_W +: tsbc_pkg::BYTE_W]),
                    .dec_key   (keys_reg[DEC_RND*tsbc_pkg::BYTE_W +: tsbc_pkg::BYTE_W]),
                    .tables    (tables_reg),
                    .take      (cell_take[j]),
                    .out_valid (cell_valid[j]),
                    .out_dec   (cell_dec[j]),
                    .out_data  (cell_data[j])
                );
            end
        end
    endgenerate

    // exit whitening for encrypt requests
    assign chain_out = (cell_dec[ROUNDS-1] == tsbc_pkg::REQ_DECRYPT)
                       ? cell_data[ROUNDS-1]
                       : (cell_data[ROUNDS-1] ^ key3);

    assign out_valid_next = out_take ? cell_valid[ROUNDS-1] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && cell_valid[ROUNDS-1])
        begin
            out_data_reg <= chain_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

    // an accepted request always lands in the first cell
    a_in_to_cell0: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> cell_valid[0])
        else $error("accepted request did not enter the first cell");

    // the chain only refuses a request when every stage is full and the output stalls
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> cell_valid[ROUNDS-1] && out_valid && !out_ready)
        else $error("request refused while the chain had room");

    // a fresh result comes only from the last cell
    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cell_valid[ROUNDS-1]))
        else $error("result appeared without a request in the last cell");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for toy_spn_byte_cipher: directed table, then random phases
// predicts untyped results from a mirror of the config regs; depends on tsbc_pkg
`default_nettype none

module tb;

    localparam int CIPHER_ROUNDS = tsbc_pkg::ROUNDS_DEFAULT;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 60;

    // indexes past the register list, writes there must be dropped
    localparam logic [tsbc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [tsbc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef enum int {MODE_BIJECTIVE, MODE_NOISE, MODE_EXTREME, MODE_RESET} cfg_mode_t;

    // one line of the directed table: a register write or a request,
    // with an optional hand-typed result
    typedef struct packed {
        row_kind_t                        kind;
        logic [tsbc_pkg::CFG_INDEX_W-1:0] idx;
        logic [tsbc_pkg::CFG_DATA_W-1:0]  val;
        logic                             rt;
        tsbc_pkg::byte_t                  din;
        logic                             typed;
        tsbc_pkg::byte_t                  want;
    } dir_row_t;

    // dut signals, all inputs known from time zero
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tsbc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tsbc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic                             req_type  = 1'b0;
    tsbc_pkg::byte_t                  data_in   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    tsbc_pkg::byte_t                  data_out;

    // mirror of the config registers, as the block holds them after reset
    logic [tsbc_pkg::KEYS_W-1:0] key_reg      = tsbc_pkg::KEYS_RESET;
    logic [tsbc_pkg::SBOX_W-1:0] sbox_reg     = tsbc_pkg::SBOX_RESET;
    logic [tsbc_pkg::SBOX_W-1:0] inv_sbox_reg = tsbc_pkg::SBOX_RESET;
    logic [tsbc_pkg::PERM_W-1:0] perm_reg     = tsbc_pkg::PERM_RESET;
    logic [tsbc_pkg::PERM_W-1:0] inv_perm_reg = tsbc_pkg::PERM_RESET;

    // bytes the block still owes us, oldest first
    tsbc_pkg::byte_t pending_bytes[$];
    dir_row_t        dir_tab[$];

    int              fail_count  = 0;
    int              cycle_count = 0;
    int              rx_wait     = 0;
    tsbc_pkg::byte_t rx_want;
    bit              no_idle     = 1'b0;

    toy_spn_byte_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out)
    );

    always #5 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // both nibbles looked up in a packed 16-entry table
    function automatic tsbc_pkg::byte_t sub_nibbles(input logic [tsbc_pkg::SBOX_W-1:0] tbl,
                                                    input tsbc_pkg::byte_t v);
        tsbc_pkg::byte_t r;
        r[7:4] = tbl[4*v[7:4] +: 4];
        r[3:0] = tbl[4*v[3:0] +: 4];
        return r;
    endfunction

    // output bit i takes input bit map[i], repeats allowed
    function automatic tsbc_pkg::byte_t shuffle_bits(input logic [tsbc_pkg::PERM_W-1:0] map,
                                                     input tsbc_pkg::byte_t v);
        tsbc_pkg::byte_t r;
        for (int i = 0; i < tsbc_pkg::BYTE_W; i++)
            r[i] = v[map[tsbc_pkg::IDX_W*i +: tsbc_pkg::IDX_W]];
        return r;
    endfunction

    function automatic tsbc_pkg::byte_t predict_cipher(input logic rt,
                                                       input tsbc_pkg::byte_t d);
        tsbc_pkg::byte_t m;
        m = d;
        if (rt == tsbc_pkg::REQ_ENCRYPT)
        begin
            for (int r = 0; r < CIPHER_ROUNDS; r++)
            begin
                m = m ^ key_reg[8*r +: 8];
                m = sub_nibbles(sbox_reg, m);
                m = shuffle_bits(perm_reg, m);
            end
            m = m ^ key_reg[31:24];
        end
        else
        begin
            // undo the rounds last to first with the inverse tables as written
            m = m ^ key_reg[31:24];
            for (int r = CIPHER_ROUNDS - 1; r >= 0; r--)
            begin
                m = shuffle_bits(inv_perm_reg, m);
                m = sub_nibbles(inv_sbox_reg, m);
                m = m ^ key_reg[8*r +: 8];
            end
        end
        return m;
    endfunction

    // ---------------------------------------------------------------
    // result side: random stalls, compare against the oldest pending byte
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $display("%0t: stray result, expected none, actual %02h",
                             $time, data_out);
                    fail_count++;
                end
                else
                begin
                    rx_want = pending_bytes.pop_front();
                    if (data_out !== rx_want)
                    begin
                        $display("%0t: data_out mismatch, expected %02h, actual %02h",
                                 $time, rx_want, data_out);
                        fail_count++;
                    end
                end
                // stall drawn per result
                rx_wait = no_idle ? 0 : $urandom_range(0, 15);
            end
            out_ready <= (rx_wait == 0);
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // valid stays high across back-to-back requests, only dropped for a gap
    task automatic send_byte(input logic rt, input tsbc_pkg::byte_t din, input logic typed,
                             input tsbc_pkg::byte_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        data_in  <= din;
        do
            @(posedge clk);
        while (!in_ready);
        // request taken at this edge, config is stable while it flies
        if (typed)
            pending_bytes.push_back(want);
        else
            pending_bytes.push_back(predict_cipher(rt, din));
    endtask

    // sender holds off until every pending byte has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // cfg_valid is left high so writes can go back to back; caller drops it
    task automatic write_reg(input logic [tsbc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [tsbc_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tsbc_pkg::CFG_ROUND_KEYS:   key_reg      = val[tsbc_pkg::KEYS_W-1:0];
            tsbc_pkg::CFG_SBOX:         sbox_reg     = val;
            tsbc_pkg::CFG_INV_SBOX:     inv_sbox_reg = val;
            tsbc_pkg::CFG_PERM_MAP:     perm_reg     = val[tsbc_pkg::PERM_W-1:0];
            tsbc_pkg::CFG_INV_PERM_MAP: inv_perm_reg = val[tsbc_pkg::PERM_W-1:0];
            default:                    ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // random config sets
    // ---------------------------------------------------------------
    task automatic program_regs(input cfg_mode_t mode);
        int                              p16[16];
        int                              p8[8];
        int                              j;
        int                              t;
        logic [tsbc_pkg::KEYS_W-1:0]     k;
        logic [tsbc_pkg::SBOX_W-1:0]     s;
        logic [tsbc_pkg::SBOX_W-1:0]     si;
        logic [tsbc_pkg::PERM_W-1:0]     pm;
        logic [tsbc_pkg::PERM_W-1:0]     pi;
        logic [tsbc_pkg::CFG_DATA_W-1:0] fill;
        drain_results();
        case (mode)
            MODE_BIJECTIVE:
            begin
                // shuffled s-box and bit order, with matching inverses
                for (int z = 0; z < 16; z++)
                    p16[z] = z;
                for (int z = 15; z > 0; z--)
                begin
                    j = $urandom_range(0, z);
                    t = p16[z]; p16[z] = p16[j]; p16[j] = t;
                end
                for (int i = 0; i < 8; i++)
                    p8[i] = i;
                for (int i = 7; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = p8[i]; p8[i] = p8[j]; p8[j] = t;
                end
                for (int z = 0; z < 16; z++)
                begin
                    s[4*z +: 4]       = 4'(p16[z]);
                    si[4*p16[z] +: 4] = 4'(z);
                end
                for (int i = 0; i < 8; i++)
                begin
                    pm[3*i +: 3]     = 3'(p8[i]);
                    pi[3*p8[i] +: 3] = 3'(i);
                end
                k = $urandom;
                write_reg(tsbc_pkg::CFG_ROUND_KEYS, {$urandom, k});
                write_reg(tsbc_pkg::CFG_SBOX, s);
                write_reg(tsbc_pkg::CFG_INV_SBOX, si);
                write_reg(tsbc_pkg::CFG_PERM_MAP, {$urandom, 8'($urandom), pm});
                write_reg(tsbc_pkg::CFG_INV_PERM_MAP, {$urandom, 8'($urandom), pi});
            end
            MODE_NOISE:
            begin
                // arbitrary bits everywhere, tables need not be inverses
                write_reg(tsbc_pkg::CFG_ROUND_KEYS, {$urandom, $urandom});
                write_reg(tsbc_pkg::CFG_SBOX, {$urandom, $urandom});
                write_reg(tsbc_pkg::CFG_INV_SBOX, {$urandom, $urandom});
                write_reg(tsbc_pkg::CFG_PERM_MAP, {$urandom, $urandom});
                write_reg(tsbc_pkg::CFG_INV_PERM_MAP, {$urandom, $urandom});
                write_reg(tsbc_pkg::CFG_INDEX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                          {$urandom, $urandom});
            end
            MODE_EXTREME:
            begin
                fill = $urandom_range(0, 1) ? '1 : '0;
                write_reg(tsbc_pkg::CFG_ROUND_KEYS, fill);
                write_reg(tsbc_pkg::CFG_SBOX, fill);
                write_reg(tsbc_pkg::CFG_INV_SBOX, ~fill);
                write_reg(tsbc_pkg::CFG_PERM_MAP, fill);
                write_reg(tsbc_pkg::CFG_INV_PERM_MAP, ~fill);
            end
            default:
            begin
                write_reg(tsbc_pkg::CFG_ROUND_KEYS, tsbc_pkg::KEYS_RESET);
                write_reg(tsbc_pkg::CFG_SBOX, tsbc_pkg::SBOX_RESET);
                write_reg(tsbc_pkg::CFG_INV_SBOX, tsbc_pkg::SBOX_RESET);
                write_reg(tsbc_pkg::CFG_PERM_MAP, tsbc_pkg::PERM_RESET);
                write_reg(tsbc_pkg::CFG_INV_PERM_MAP, tsbc_pkg::PERM_RESET);
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    function automatic dir_row_t row_req(input logic rt, input tsbc_pkg::byte_t din,
                                         input logic typed, input tsbc_pkg::byte_t want);
        dir_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.rt    = rt;
        r.din   = din;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input logic [tsbc_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [tsbc_pkg::CFG_DATA_W-1:0] val);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        bit              cfg_open;
        cfg_mode_t       mode;
        tsbc_pkg::byte_t plain;
        tsbc_pkg::byte_t ct;
        int              sent;

        // after reset: zero keys and identity tables pass bytes straight through
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'h00, 1'b1, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'hFF, 1'b1, 8'hFF));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'h00, 1'b1, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'hFF, 1'b1, 8'hFF));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'hA5, 1'b1, 8'hA5));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'h5A, 1'b1, 8'h5A));
        // all-zero s-box: every encryption collapses to key3; upper key bits dropped
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_ROUND_KEYS, 64'hFFFF_0000_C3A5_5A3C));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_SBOX, 64'h0));
        // writes past the register list must change nothing
        dir_tab.push_back(row_cfg(CFG_UNUSED_LO, '1));
        dir_tab.push_back(row_cfg(CFG_UNUSED_HI, 64'h0123_4567_89AB_CDEF));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'h00, 1'b1, 8'hC3));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'hFF, 1'b1, 8'hC3));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'hFF, 1'b0, 8'h00));
        // non-bijective maps: every bit copies bit 0 forward, bit 7 backward
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_ROUND_KEYS, 64'h0));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_SBOX, tsbc_pkg::SBOX_RESET));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_PERM_MAP, 64'h0));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_INV_PERM_MAP, '1));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'h01, 1'b1, 8'hFF));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'hFE, 1'b1, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'h80, 1'b1, 8'hFF));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'h7F, 1'b1, 8'h00));
        // complement s-box and bit reversal, both their own inverse
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_ROUND_KEYS, 64'h0000_0000_8001_7EFF));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_SBOX, 64'h0123_4567_89AB_CDEF));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_INV_SBOX, 64'h0123_4567_89AB_CDEF));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_PERM_MAP, 64'h05_3977));
        dir_tab.push_back(row_cfg(tsbc_pkg::CFG_INV_PERM_MAP, 64'h05_3977));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'h00, 1'b0, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_ENCRYPT, 8'hFF, 1'b0, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'h3C, 1'b0, 8'h00));
        dir_tab.push_back(row_req(tsbc_pkg::REQ_DECRYPT, 8'hC3, 1'b0, 8'h00));

        // single reset at the start
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, block drained before each run of register writes
        cfg_open = 1'b0;
        foreach (dir_tab[n])
        begin
            if (dir_tab[n].kind == ROW_CFG)
            begin
                if (!cfg_open)
                    drain_results();
                write_reg(dir_tab[n].idx, dir_tab[n].val);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_byte(dir_tab[n].rt, dir_tab[n].din, dir_tab[n].typed, dir_tab[n].want);
            end
        end

        // random phases, proper ciphers among them with encrypt/decrypt round trips
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 3)
                mode = MODE_EXTREME;
            else if (ph == 6)
                mode = MODE_RESET;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: mode = MODE_BIJECTIVE;
                    6, 7:             mode = MODE_NOISE;
                    8:                mode = MODE_EXTREME;
                    default:          mode = MODE_RESET;
                endcase
            end
            program_regs(mode);
            // some phases run with no idling on either side
            no_idle = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // occasional hold-off until the pipe is empty
                if ($urandom_range(0, 39) == 0)
                    drain_results();
                plain = 8'($urandom);
                if (mode == MODE_BIJECTIVE && $urandom_range(0, 2) != 0)
                begin
                    // round trip: ciphertext fed straight back for decryption
                    ct = predict_cipher(tsbc_pkg::REQ_ENCRYPT, plain);
                    send_byte(tsbc_pkg::REQ_ENCRYPT, plain, 1'b0, 8'h00);
                    send_byte(tsbc_pkg::REQ_DECRYPT, ct, 1'b0, 8'h00);
                    sent += 2;
                end
                else
                begin
                    send_byte(1'($urandom), plain, 1'b0, 8'h00);
                    sent++;
                end
            end
        end

        // wait out the pipe, then watch for stray results
        no_idle = 1'b0;
        drain_results();
        repeat (CIPHER_ROUNDS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
